[rtl/sprd_pkg.sv]
// Shared types and constants for the stripe pattern row detector.
`default_nettype none

package sprd_pkg;

  localparam int unsigned COLOR_W     = 3;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned WIN_W       = 7;
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // Run length loaded at the start of each row.
  localparam int unsigned RUN_START = 10;

  localparam logic [COLOR_W-1:0] COLOR_A_RST   = 3'd6;
  localparam logic [COLOR_W-1:0] COLOR_B_RST   = 3'd4;
  localparam logic [LIMIT_W-1:0] MIN_RUN_RST   = 8'd7;
  localparam logic [LIMIT_W-1:0] STRIPE_LIM_RST = 8'd5;
  localparam logic [WIN_W-1:0]   WIN_ROWS_RST  = 7'd10;
  localparam logic [WIN_W-1:0]   WIN_THR_RST   = 7'd7;

  typedef struct packed {
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic [LIMIT_W-1:0] min_run;
    logic [LIMIT_W-1:0] stripe_limit;
    logic [WIN_W-1:0]   window_rows;
    logic [WIN_W-1:0]   window_threshold;
  } cfg_t;

  // Row close event from the stripe scanner to the window counter.
  typedef struct packed {
    logic close;
    logic frame;
    logic flag;
  } row_close_t;

  typedef struct packed {
    logic             path_open;
    logic [ROW_W-1:0] detect_row;
  } res_t;

endpackage

`default_nettype wire

[rtl/sprd_cfg.sv]
// Configuration register file of the stripe pattern row detector.
`default_nettype none

module sprd_cfg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               wr_en_i,
  input  wire [sprd_pkg::CFG_INDEX_W-1:0]   wr_index_i,
  input  wire [sprd_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output sprd_pkg::cfg_t                    cfg_o
);
  import sprd_pkg::*;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_A      = 3'd0,
    REG_COLOR_B      = 3'd1,
    REG_MIN_RUN      = 3'd2,
    REG_STRIPE_LIMIT = 3'd3,
    REG_WINDOW_ROWS  = 3'd4,
    REG_WINDOW_THR   = 3'd5
  } reg_index_e;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_COLOR_A:      cfg_d.color_a          = wr_data_i[COLOR_W-1:0];
        REG_COLOR_B:      cfg_d.color_b          = wr_data_i[COLOR_W-1:0];
        REG_MIN_RUN:      cfg_d.min_run          = wr_data_i[LIMIT_W-1:0];
        REG_STRIPE_LIMIT: cfg_d.stripe_limit     = wr_data_i[LIMIT_W-1:0];
        REG_WINDOW_ROWS:  cfg_d.window_rows      = wr_data_i[WIN_W-1:0];
        REG_WINDOW_THR:   cfg_d.window_threshold = wr_data_i[WIN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_a          <= COLOR_A_RST;
      cfg_q.color_b          <= COLOR_B_RST;
      cfg_q.min_run          <= MIN_RUN_RST;
      cfg_q.stripe_limit     <= STRIPE_LIM_RST;
      cfg_q.window_rows      <= WIN_ROWS_RST;
      cfg_q.window_threshold <= WIN_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/sprd_row.sv]
// Per-row stripe scanner: run length, stripe color and transition count.
`default_nettype none

module sprd_row #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire [sprd_pkg::COLOR_W-1:0]    pixel_color_i,
  input  wire                            row_end_i,
  input  wire                            frame_end_i,
  input  sprd_pkg::cfg_t                 cfg_i,
  output sprd_pkg::row_close_t           close_o
);
  import sprd_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] RUN_RST   = COUNT_BITS'(RUN_START);
  localparam logic [COUNT_BITS-1:0] RUN_ONE   = COUNT_BITS'(1);

  typedef enum logic [1:0] {
    STRIPE_A    = 2'd0,
    STRIPE_B    = 2'd1,
    STRIPE_NONE = 2'd2
  } stripe_e;

  stripe_e               stripe_q, stripe_d, kind;
  logic [COUNT_BITS-1:0] run_q, run_d, run_a, run_b;
  logic [COUNT_BITS-1:0] trans_q, trans_d, trans_n;
  logic                  row_done;

  // Color A test first, then color B on the run that A left behind.
  always_comb begin
    kind  = STRIPE_NONE;
    run_a = run_q;
    if (pixel_color_i == cfg_i.color_a) begin
      if (stripe_q == STRIPE_A) begin
        kind  = STRIPE_A;
        run_a = (run_q == CNT_MAX) ? run_q : run_q + RUN_ONE;
      end else if (CMP_W'(run_q) > CMP_W'(cfg_i.min_run)) begin
        kind  = STRIPE_A;
        run_a = RUN_ONE;
      end
    end
    run_b = run_a;
    if (pixel_color_i == cfg_i.color_b) begin
      if (stripe_q == STRIPE_B) begin
        kind  = STRIPE_B;
        run_b = (run_a == CNT_MAX) ? run_a : run_a + RUN_ONE;
      end else if (CMP_W'(run_a) > CMP_W'(cfg_i.min_run)) begin
        kind  = STRIPE_B;
        run_b = RUN_ONE;
      end
    end
  end

  always_comb begin
    trans_n  = trans_q;
    stripe_d = stripe_q;
    if (kind != STRIPE_NONE && kind != stripe_q) begin
      stripe_d = kind;
      trans_n  = (trans_q == CNT_MAX) ? trans_q : trans_q + RUN_ONE;
    end
    run_d   = run_b;
    trans_d = trans_n;
    row_done = row_end_i || frame_end_i;
    if (row_done) begin
      stripe_d = STRIPE_NONE;
      run_d    = RUN_RST;
      trans_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stripe_q <= STRIPE_NONE;
      run_q    <= RUN_RST;
      trans_q  <= '0;
    end else if (en_i) begin
      stripe_q <= stripe_d;
      run_q    <= run_d;
      trans_q  <= trans_d;
    end
  end

  assign close_o.close = row_done;
  assign close_o.frame = frame_end_i;
  assign close_o.flag  = CMP_W'(trans_n) > CMP_W'(cfg_i.stripe_limit);

endmodule

`default_nettype wire

[rtl/sprd_win.sv]
// Sliding window of row flags, detection latch and row index.
`default_nettype none

module sprd_win #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  sprd_pkg::row_close_t  close_i,
  input  sprd_pkg::cfg_t        cfg_i,
  output sprd_pkg::res_t        res_o
);
  import sprd_pkg::*;

  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WSEL_W = ($clog2(MAX_WINDOW + 1) > WIN_W) ?
                                   $clog2(MAX_WINDOW + 1) : WIN_W;
  localparam logic [WSEL_W-1:0] WIN_MAX = WSEL_W'(MAX_WINDOW);
  localparam logic [ROW_W-1:0]  ROW_MAX = {ROW_W{1'b1}};

  logic [MAX_WINDOW-1:0] hist_q, hist_d;
  logic [WIN_W-1:0]      count_q, count_d, count_n;
  logic                  det_q, det_d, det_n;
  logic [ROW_W-1:0]      hit_q, hit_d, hit_n;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [WSEL_W-1:0]     win_len;
  logic [IDX_W-1:0]      old_idx;
  logic                  leaving;

  always_comb begin
    win_len = (WSEL_W'(cfg_i.window_rows) > WIN_MAX) ? WIN_MAX :
              WSEL_W'(cfg_i.window_rows);
    old_idx = IDX_W'(win_len - WSEL_W'(1));
    leaving = (win_len == '0) ? close_i.flag : hist_q[old_idx];
    count_n = count_q + WIN_W'(close_i.flag) - WIN_W'(leaving);

    det_n = det_q;
    hit_n = hit_q;
    if (!det_q && count_n >= cfg_i.window_threshold) begin
      det_n = 1'b1;
      hit_n = row_q;
    end

    hist_d[0] = close_i.flag;
    for (int i = 1; i < MAX_WINDOW; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    count_d = count_n;
    det_d   = det_n;
    hit_d   = hit_n;
    row_d   = (row_q == ROW_MAX) ? row_q : row_q + ROW_W'(1);

    // Clear all frame state once the frame's result is out.
    if (close_i.frame) begin
      hist_d  = '0;
      count_d = '0;
      det_d   = 1'b0;
      hit_d   = '0;
      row_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      count_q <= '0;
      det_q   <= 1'b0;
      hit_q   <= '0;
      row_q   <= '0;
    end else if (en_i && close_i.close) begin
      hist_q  <= hist_d;
      count_q <= count_d;
      det_q   <= det_d;
      hit_q   <= hit_d;
      row_q   <= row_d;
    end
  end

  assign res_o.path_open  = !det_n;
  assign res_o.detect_row = det_n ? hit_n : '0;

endmodule

`default_nettype wire

[rtl/stripe_pattern_row_detector.sv]
// A frame-end pixel is registered in the pixel stage, then its result in the result register.
// Throughput: one pixel per cycle; the input only stalls while a result waits downstream.
// Pixel stage, row scanner and window update all sit between the input and result registers.
// Reset (rst_ni low, asynchronous): configuration returns to defaults, frame state clears,
// and both pipeline stages are emptied.
`default_nettype none

module stripe_pattern_row_detector #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire [sprd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [2:0] pixel_color, rest zero
  input  wire                                  s_axis_tlast,  // frame_end
  input  wire                                  s_axis_tuser,  // [0] row_end
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [sprd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [0] path_open, [8:1] detect_row
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [sprd_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire [sprd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import sprd_pkg::*;

  cfg_t             cfg;
  row_close_t       row_close;
  res_t             res, res_q;
  logic             advance, fire;
  logic             s1_valid_q;
  logic [COLOR_W-1:0] s1_color_q;
  logic             s1_row_end_q, s1_frame_end_q;
  logic             out_valid_q;

  assign cfg_ready_o = 1'b1;

  sprd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move both stages together whenever the result register is free.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && advance;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= s_axis_tvalid;
      out_valid_q <= fire && s1_frame_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_axis_tvalid) begin
      s1_color_q     <= s_axis_tdata[COLOR_W-1:0];
      s1_row_end_q   <= s_axis_tuser;
      s1_frame_end_q <= s_axis_tlast;
    end
    if (fire && s1_frame_end_q) begin
      res_q <= res;
    end
  end

  sprd_row #(
    .COUNT_BITS (COUNT_BITS)
  ) u_row (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .pixel_color_i (s1_color_q),
    .row_end_i     (s1_row_end_q),
    .frame_end_i   (s1_frame_end_q),
    .cfg_i         (cfg),
    .close_o       (row_close)
  );

  sprd_win #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .close_i (row_close),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ROW_W - 1){1'b0}}, res_q.detect_row, res_q.path_open};

endmodule

`default_nettype wire

[rtl/sprd_checker.sv]
// Port-level checker for the stripe pattern row detector, bound to the top level.
`default_nettype none

module sprd_checker (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tready,
  input  wire                                  m_axis_tvalid,
  input  wire                                  m_axis_tready,
  input  wire [sprd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import sprd_pkg::*;

  // Reset seen at an edge leaves no result pending afterwards.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds its transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // Input backpressure only comes from a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no result waiting");

  // An open path carries no detection row, and padding stays zero.
  a_open_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:ROW_W+1] == '0) &&
                      (!m_axis_tdata[0] || m_axis_tdata[ROW_W:1] == '0))
    else $error("detection row set on an open path");

endmodule

bind stripe_pattern_row_detector sprd_checker u_sprd_checker (.*);

`default_nettype wire

[tb/stripe_pattern_row_detector_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the stripe pattern row detector: predicts and checks frame results.
module stripe_pattern_row_detector_tb;
  import sprd_pkg::*;

  localparam int unsigned HIST_DEPTH   = 64;
  localparam logic [7:0]  COUNT_SAT    = 8'hFF;
  localparam logic [7:0]  ROW_SAT      = 8'hFF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_A          = 3'd0,
    REG_COLOR_B          = 3'd1,
    REG_MIN_RUN          = 3'd2,
    REG_STRIPE_LIMIT     = 3'd3,
    REG_WINDOW_ROWS      = 3'd4,
    REG_WINDOW_THRESHOLD = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STRIPE_A    = 2'd0,
    STRIPE_B    = 2'd1,
    STRIPE_NONE = 2'd2
  } stripe_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Predictor state
  cfg_t                  model_cfg;
  stripe_e               cur_stripe;
  logic [7:0]            run_len;
  logic [7:0]            trans_cnt;
  logic [HIST_DEPTH-1:0] flag_hist;
  logic [6:0]            flagged_rows;
  logic                  frame_hit;
  logic [7:0]            row_idx;
  logic [7:0]            hit_row;
  res_t                  frame_results[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned random_frames = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  stripe_pattern_row_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frames still pending", cycle_count,
               frame_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic clear_row();
    cur_stripe = STRIPE_NONE;
    run_len    = 8'(RUN_START);
    trans_cnt  = '0;
  endtask

  task automatic clear_frame();
    clear_row();
    flag_hist    = '0;
    flagged_rows = '0;
    frame_hit    = 1'b0;
    row_idx      = '0;
    hit_row      = '0;
  endtask

  task automatic scan_pixel(input logic [COLOR_W-1:0] color);
    stripe_e prev;
    stripe_e kind;
    prev = cur_stripe;
    kind = STRIPE_NONE;
    // Both color tests look at the stripe held before this pixel
    if (color == model_cfg.color_a) begin
      if (prev == STRIPE_A) begin
        kind = STRIPE_A;
        if (run_len != COUNT_SAT) run_len++;
      end else if (run_len > model_cfg.min_run) begin
        kind    = STRIPE_A;
        run_len = 8'd1;
      end
    end
    if (color == model_cfg.color_b) begin
      if (prev == STRIPE_B) begin
        kind = STRIPE_B;
        if (run_len != COUNT_SAT) run_len++;
      end else if (run_len > model_cfg.min_run) begin
        kind    = STRIPE_B;
        run_len = 8'd1;
      end
    end
    if (kind != STRIPE_NONE && kind != prev) begin
      cur_stripe = kind;
      if (trans_cnt != COUNT_SAT) trans_cnt++;
    end
  endtask

  task automatic close_row();
    int unsigned span;
    logic        flag;
    logic        leaving;
    span    = (model_cfg.window_rows > HIST_DEPTH) ? HIST_DEPTH : model_cfg.window_rows;
    flag    = (trans_cnt > model_cfg.stripe_limit);
    // An empty window drops the new flag at once
    leaving = (span > 0) ? flag_hist[span-1] : flag;
    flag_hist    = {flag_hist[HIST_DEPTH-2:0], flag};
    flagged_rows = flagged_rows + {6'd0, flag} - {6'd0, leaving};
    if (!frame_hit && flagged_rows >= model_cfg.window_threshold) begin
      frame_hit = 1'b1;
      hit_row   = row_idx;
    end
    if (row_idx != ROW_SAT) row_idx++;
    clear_row();
  endtask

  task automatic predict_pixel(input logic [COLOR_W-1:0] color, input logic row_end,
                               input logic frame_end);
    res_t r;
    scan_pixel(color);
    if (row_end || frame_end) close_row();
    if (frame_end) begin
      r.path_open  = !frame_hit;
      r.detect_row = frame_hit ? hit_row : '0;
      frame_results.push_back(r);
      frames_sent++;
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_results.size() == 0) begin
        report_mismatch("unexpected frame result, tdata", 32'(m_axis_tdata), 0);
      end else begin
        want = frame_results.pop_front();
        frames_checked++;
        if (m_axis_tdata[0] !== want.path_open)
          report_mismatch("path_open", 32'(m_axis_tdata[0]), 32'(want.path_open));
        if (m_axis_tdata[8:1] !== want.detect_row)
          report_mismatch("detect_row", 32'(m_axis_tdata[8:1]), 32'(want.detect_row));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic row_end,
                            input logic frame_end);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(color);
    s_axis_tuser  <= row_end;
    s_axis_tlast  <= frame_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(color, row_end, frame_end);
    pixels_sent++;
  endtask

  task automatic send_run(input logic [COLOR_W-1:0] color, input int count,
                          input logic row_end, input logic frame_end);
    for (int i = 0; i < count; i++)
      send_pixel(color, row_end && (i == count - 1), frame_end && (i == count - 1));
  endtask

  // Drop valid, drain all pending frames, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_COLOR_A:          model_cfg.color_a          = value[COLOR_W-1:0];
      REG_COLOR_B:          model_cfg.color_b          = value[COLOR_W-1:0];
      REG_MIN_RUN:          model_cfg.min_run          = value[LIMIT_W-1:0];
      REG_STRIPE_LIMIT:     model_cfg.stripe_limit     = value[LIMIT_W-1:0];
      REG_WINDOW_ROWS:      model_cfg.window_rows      = value[WIN_W-1:0];
      REG_WINDOW_THRESHOLD: model_cfg.window_threshold = value[WIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] ca, input logic [7:0] cb,
                              input logic [7:0] min_run, input logic [7:0] limit,
                              input logic [7:0] win, input logic [7:0] thr);
    settle();
    write_reg(REG_COLOR_A, ca);
    write_reg(REG_COLOR_B, cb);
    write_reg(REG_MIN_RUN, min_run);
    write_reg(REG_STRIPE_LIMIT, limit);
    write_reg(REG_WINDOW_ROWS, win);
    write_reg(REG_WINDOW_THRESHOLD, thr);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_config();
    send_pixel(3'd6, 1'b0, 1'b1);
    send_run(3'd6, 9, 1'b0, 1'b0);
    send_run(3'd4, 8, 1'b1, 1'b0);
    send_pixel(3'd4, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    apply_config(8'd0, 8'd7, 8'd0, 8'd0, 8'd1, 8'd1);
    for (int c = 0; c < 8; c++) send_pixel(COLOR_W'(c), c == 7, 1'b0);
    send_pixel(3'd7, 1'b1, 1'b1);
    send_run(3'd3, 3, 1'b1, 1'b0);
    send_pixel(3'd1, 1'b0, 1'b1);
  endtask

  task automatic test_equal_colors();
    apply_config(8'd3, 8'd3, 8'd0, 8'd0, 8'd1, 8'd1);
    send_run(3'd3, 3, 1'b0, 1'b0);
    send_pixel(3'd5, 1'b0, 1'b0);
    send_pixel(3'd3, 1'b1, 1'b1);
    apply_config(8'd5, 8'd5, 8'd2, 8'd1, 8'd2, 8'd1);
    send_run(3'd5, 4, 1'b0, 1'b0);
    send_pixel(3'd2, 1'b0, 1'b0);
    send_run(3'd5, 3, 1'b1, 1'b1);
  endtask

  task automatic test_window_edges();
    // Zero threshold fires at the first row end
    apply_config(8'd6, 8'd4, 8'd7, 8'd5, 8'd10, 8'd0);
    send_run(3'd1, 3, 1'b1, 1'b0);
    send_run(3'd6, 2, 1'b1, 1'b1);
    // Threshold above the window never fires
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd5, 8'd6);
    send_run(3'd6, 8, 1'b1, 1'b1);
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd127, 8'd127);
    send_run(3'd6, 3, 1'b1, 1'b1);
    // Empty window never counts a flag
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd0, 8'd1);
    send_run(3'd6, 4, 1'b1, 1'b1);
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
    send_run(3'd6, 2, 1'b1, 1'b1);
    // Sliding out of a short window, then rows after the hit
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd3, 8'd2);
    send_pixel(3'd6, 1'b1, 1'b0);
    send_run(3'd0, 2, 1'b1, 1'b0);
    send_run(3'd6, 2, 1'b1, 1'b0);
    send_pixel(3'd0, 1'b1, 1'b0);
    send_run(3'd6, 3, 1'b1, 1'b1);
    // Full window, and a window wider than the history
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd64, 8'd64);
    send_run(3'd6, 64, 1'b1, 1'b0);
    send_pixel(3'd0, 1'b0, 1'b1);
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd127, 8'd64);
    send_run(3'd6, 66, 1'b1, 1'b1);
  endtask

  task automatic test_saturation();
    // A run of 256 must stay long enough to switch with min_run zero
    apply_config(8'd6, 8'd4, 8'd0, 8'd1, 8'd1, 8'd1);
    send_run(3'd6, 256, 1'b0, 1'b0);
    send_pixel(3'd4, 1'b1, 1'b1);
    send_run(3'd4, 260, 1'b0, 1'b0);
    send_pixel(3'd6, 1'b0, 1'b1);
    // Transition count clamps at full scale
    apply_config(8'd6, 8'd4, 8'd0, 8'd254, 8'd1, 8'd1);
    for (int i = 0; i < 260; i++) send_pixel(i[0] ? 3'd4 : 3'd6, 1'b0, i == 259);
    apply_config(8'd6, 8'd4, 8'd0, 8'd255, 8'd1, 8'd1);
    for (int i = 0; i < 260; i++) send_pixel(i[0] ? 3'd4 : 3'd6, 1'b0, i == 259);
    // Row index clamps at 255
    apply_config(8'd6, 8'd4, 8'd0, 8'd0, 8'd1, 8'd1);
    send_run(3'd0, 259, 1'b1, 1'b0);
    send_pixel(3'd6, 1'b1, 1'b1);
  endtask

  task automatic random_config();
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] min_run;
    logic [7:0] limit;
    logic [7:0] win;
    logic [7:0] thr;
    ca      = 8'($urandom_range(0, 7));
    cb      = ($urandom_range(0, 9) == 0) ? ca : 8'($urandom_range(0, 7));
    min_run = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 12));
    limit   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 6));
    win     = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 10));
    thr     = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, (win & 8'h7F) + 1));
    apply_config(ca, cb, min_run, limit, win, thr);
  endtask

  // Rows of alternating stripes sized around min_run, with stray colors mixed in
  task automatic random_frame();
    int                 n_rows;
    int                 n_stripes;
    int                 lo;
    int                 hi;
    logic               pick_b;
    logic               last_pix;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] row_pix[$];
    n_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    hi     = (model_cfg.min_run > 17) ? 20 : model_cfg.min_run + 3;
    lo     = (model_cfg.min_run > 17 || model_cfg.min_run == 0) ? 1 : model_cfg.min_run - 1;
    for (int r = 0; r < n_rows; r++) begin
      row_pix.delete();
      n_stripes = $urandom_range(0, 7);
      pick_b    = 1'($urandom_range(0, 1));
      for (int s = 0; s < n_stripes; s++) begin
        color  = ($urandom_range(0, 7) == 0) ? COLOR_W'($urandom_range(0, 7))
                                             : (pick_b ? model_cfg.color_b : model_cfg.color_a);
        pick_b = !pick_b;
        repeat ($urandom_range(lo, hi)) row_pix.push_back(color);
      end
      if (row_pix.size() == 0) row_pix.push_back(COLOR_W'($urandom_range(0, 7)));
      for (int i = 0; i < row_pix.size(); i++) begin
        last_pix = (i == row_pix.size() - 1);
        if (last_pix && r == n_rows - 1)
          send_pixel(row_pix[i], 1'($urandom_range(0, 1)), 1'b1);
        else
          send_pixel(row_pix[i], last_pix, 1'b0);
      end
    end
    random_frames++;
  endtask

  task automatic test_random();
    int unsigned target;
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 46 : 0;
      rx_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 31 : 0;
      target      = pixels_sent + RANDOM_ITEMS / 3;
      random_config();
      while (pixels_sent < target) begin
        if ($urandom_range(0, 4) == 0) random_config();
        random_frame();
      end
    end
  endtask

  initial begin
    model_cfg = '{color_a: COLOR_A_RST, color_b: COLOR_B_RST, min_run: MIN_RUN_RST,
                  stripe_limit: STRIPE_LIM_RST, window_rows: WIN_ROWS_RST,
                  window_threshold: WIN_THR_RST};
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 31;
    rx_idle_pct = 46;
    test_reset_config();
    test_field_extremes();
    test_equal_colors();
    test_window_edges();
    test_saturation();
    test_random();
    settle();

    $display("Sent %0d pixels in %0d frames (%0d random), %0d register writes",
             pixels_sent, frames_sent, random_frames, reg_writes);
    $display("Checked %0d frame results, %0d mismatches", frames_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sprd_pkg.sv
rtl/sprd_cfg.sv
rtl/sprd_row.sv
rtl/sprd_win.sv
rtl/stripe_pattern_row_detector.sv
rtl/sprd_checker.sv
tb/stripe_pattern_row_detector_tb.sv
